/* rtl/core/random_permutation_shuffler_unit_assert.svh */
// assertion macros for the permutation shuffler
`ifndef RANDOM_PERMUTATION_SHUFFLER_UNIT_ASSERT_SVH
`define RANDOM_PERMUTATION_SHUFFLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RPSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RPSU_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/rpsu_pkg.sv */
package rpsu_pkg;

    localparam int SIZE_W   = 9;
    localparam int VALUE_W  = 9;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 31;
    localparam int MAX_SIZE = 2 ** POS_W;

    localparam int DEF_MAX_ELEMENTS = 256;
    localparam int DEF_RANDOM_BITS  = 31;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

/* rtl/core/rpsu_front.sv */
module rpsu_front #(
    parameter int RB = rpsu_pkg::DEF_RANDOM_BITS,
    parameter int IW = 8,
    parameter int NW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic [NW-1:0]        i_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [RB-1:0]        i_word,
    output logic                 o_push,
    output logic [2*IW:0]        o_job,
    input  rpsu_pkg::t_q_status  i_q
);

    localparam int CW = $clog2(RB);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state        r_state;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_i;
    logic [NW-1:0] r_span;
    logic [NW-1:0] r_rem;
    logic [RB-1:0] r_word;
    logic [CW-1:0] r_cnt;

    logic [NW:0]   rem_sh;
    logic [NW-1:0] rem_nx;
    logic [IW-1:0] pos_start;
    logic          accept;
    logic          last;

    // one restoring step of word mod span
    assign rem_sh    = {r_rem, r_word[RB-1]};
    assign rem_nx    = (rem_sh >= {1'b0, r_span}) ? NW'(rem_sh - {1'b0, r_span}) : NW'(rem_sh);
    assign pos_start = (NW'(r_pos) >= i_n) ? '0 : r_pos;
    assign last      = (NW'(r_i) == (i_n - NW'(1)));
    assign accept    = i_valid && (r_state == S_IDLE);

    assign o_stall = (r_state != S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_q.full;
    assign o_job   = {r_i, IW'(r_i + IW'(r_rem)), last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_i     <= pos_start;
                        r_span  <= i_n - NW'(pos_start);
                        r_word  <= i_word;
                        r_rem   <= '0;
                        r_cnt   <= CW'(RB - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_nx;
                    r_word <= {r_word[RB-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_PUSH: begin
                    if (!i_q.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_clear) begin
                r_pos <= '0;
            end else if (o_push) begin
                r_pos <= last ? '0 : IW'(r_i + 1'b1);
            end
        end
    end

endmodule

/* rtl/core/rpsu_queue.sv */
module rpsu_queue #(
    parameter int WIDTH = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output rpsu_pkg::t_q_status  o_status
);

    localparam logic [1:0] FULL_CNT = 2'd2;

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_data         = r_slot[r_rp];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/rpsu_back.sv */
module rpsu_back #(
    parameter int DEPTH = rpsu_pkg::DEF_MAX_ELEMENTS,
    parameter int IW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  rpsu_pkg::t_q_status           i_q,
    input  logic [2*IW:0]                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rpsu_pkg::VALUE_W-1:0]  o_value,
    output logic [rpsu_pkg::POS_W-1:0]    o_position,
    output logic                          o_last
);

    localparam int VW = rpsu_pkg::VALUE_W;
    localparam int PW = rpsu_pkg::POS_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SWAP} t_state;

    t_state           r_state;
    logic [VW-1:0]    r_table [DEPTH];
    logic [DEPTH-1:0] r_marks;
    logic [VW-1:0]    r_rd_i;
    logic [VW-1:0]    r_rd_j;
    logic             r_ti;
    logic             r_tj;
    logic [IW-1:0]    r_i;
    logic [IW-1:0]    r_j;
    logic             r_last;
    logic [VW-1:0]    r_vj;
    logic             r_out_valid;
    logic [VW-1:0]    r_value;
    logic [PW-1:0]    r_position;
    logic             r_out_last;

    logic [IW-1:0]    job_i;
    logic [IW-1:0]    job_j;
    logic             job_last;
    logic [VW-1:0]    vi;
    logic [VW-1:0]    vj;
    logic             out_free;
    logic             swap_fire;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [VW-1:0]    wdata;

    assign job_i    = i_job[2*IW:IW+1];
    assign job_j    = i_job[IW:1];
    assign job_last = i_job[0];

    // untouched entries read as index plus one
    assign vi = r_ti ? r_rd_i : VW'(VW'(r_i) + VW'(1));
    assign vj = r_tj ? r_rd_j : VW'(VW'(r_j) + VW'(1));

    assign o_pop     = (r_state == S_IDLE) && !i_q.empty;
    assign out_free  = !r_out_valid || !i_stall;
    assign swap_fire = (r_state == S_SWAP) && out_free;
    assign we        = (r_state == S_READ) || swap_fire;
    assign waddr     = (r_state == S_READ) ? r_j : r_i;
    assign wdata     = (r_state == S_READ) ? vi : r_vj;

    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_position = r_position;
    assign o_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[waddr] <= wdata;
        end
        if (o_pop) begin
            r_rd_i <= r_table[job_i];
            r_rd_j <= r_table[job_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (i_clear || (swap_fire && r_last)) begin
            r_marks <= '0;
        end else if (we) begin
            r_marks[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (swap_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_i     <= job_i;
                        r_j     <= job_j;
                        r_last  <= job_last;
                        r_ti    <= r_marks[job_i];
                        r_tj    <= r_marks[job_j];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_vj    <= vj;
                    r_state <= S_SWAP;
                end
                S_SWAP: begin
                    if (out_free) begin
                        r_value     <= r_vj;
                        r_position  <= PW'(r_i);
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/random_permutation_shuffler_unit.sv */
// Forward Fisher-Yates shuffler: each accepted random word fills one position i of the
// current permutation of 1..N, swapping in entry j = i + (word mod (N-i)) and returning
// the value now final at i, with a flag on position N-1, after which a new permutation
// starts. A write to perm_size restarts the permutation. The front takes one request at a
// time and stalls new ones while its bit-serial modulo divider runs and until its job is
// queued; the table swap in the back (read, two writes) overlaps it through a two-entry
// queue, and the result is registered at the output along with the swap's write to i.
`include "random_permutation_shuffler_unit_assert.svh"

module random_permutation_shuffler_unit #(
    parameter int MAX_ELEMENTS = rpsu_pkg::DEF_MAX_ELEMENTS,
    parameter int RANDOM_BITS  = rpsu_pkg::DEF_RANDOM_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpsu_pkg::SIZE_W-1:0]   i_perm_size,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rpsu_pkg::WORD_W-1:0]   i_random_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rpsu_pkg::VALUE_W-1:0]  o_perm_value,
    output logic [rpsu_pkg::POS_W-1:0]    o_perm_position,
    output logic                          o_last_of_perm
);

    localparam int DEPTH = (MAX_ELEMENTS < rpsu_pkg::MAX_SIZE) ? MAX_ELEMENTS
                                                                : rpsu_pkg::MAX_SIZE;
    localparam int IW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int RB    = (RANDOM_BITS < rpsu_pkg::WORD_W) ? RANDOM_BITS : rpsu_pkg::WORD_W;
    localparam int JW    = 2 * IW + 1;
    localparam int CMPW  = rpsu_pkg::SIZE_W + 1;
    localparam int PW    = rpsu_pkg::POS_W;

    logic [rpsu_pkg::SIZE_W-1:0] r_perm_size;
    logic [NW-1:0]               n;
    logic                        cfg_we;
    logic                        push;
    logic [JW-1:0]               push_job;
    logic                        pop;
    logic [JW-1:0]               pop_job;
    rpsu_pkg::t_q_status         q_status;
    logic [PW-1:0]               last_pos;
    logic                        last_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_size <= rpsu_pkg::SIZE_RESET;
        end else if (cfg_we) begin
            r_perm_size <= i_perm_size;
        end
    end

    // zero means one element, oversize clamps to the table depth
    always_comb begin
        priority if (r_perm_size == '0) begin
            n = NW'(1);
        end else if ({1'b0, r_perm_size} > CMPW'(DEPTH)) begin
            n = NW'(DEPTH);
        end else begin
            n = NW'(r_perm_size);
        end
    end

    rpsu_front #(
        .RB (RB),
        .IW (IW),
        .NW (NW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_we),
        .i_n     (n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (i_random_word[RB-1:0]),
        .o_push  (push),
        .o_job   (push_job),
        .i_q     (q_status)
    );

    rpsu_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .i_pop    (pop),
        .o_data   (pop_job),
        .o_status (q_status)
    );

    rpsu_back #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_we),
        .i_q        (q_status),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_value    (o_perm_value),
        .o_position (o_perm_position),
        .o_last     (o_last_of_perm)
    );

    assign last_pos = PW'(n - NW'(1));
    assign last_out = o_out_valid && o_last_of_perm;

    `RPSU_ASSERT_IMP(a_value_nonzero, i_clk, i_rst_n, o_out_valid, o_perm_value != '0)
    `RPSU_ASSERT_IMP(a_last_position, i_clk, i_rst_n, last_out, o_perm_position == last_pos)
    `RPSU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule
